// ----- hdl/mbfc03_pkg.sv -----
`default_nettype none

package mbfc03_pkg;

    // Frame layout and CRC-16/Modbus constants
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [8:0]  POS_MAX      = 9'd511;
    localparam logic [8:0]  POS_COUNT    = 9'd2;
    localparam logic [8:0]  HEADER_LEN   = 9'd3;
    localparam logic [8:0]  MIN_LEN      = 9'd5;
    localparam logic [5:0]  MAX_REGS_RST = 6'd32;

    // Result item kinds
    localparam logic ITEM_REG    = 1'b0;
    localparam logic ITEM_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_ODD_COUNT = 3'd2,
        ST_TOO_MANY  = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_CRC_BAD   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_RECV,
        S_EVAL,
        S_READ,
        S_LOAD,
        S_STAT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic byte_en;
        logic idx_clr;
        logic rd_en;
        logic load_reg;
        logic load_stat;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic frame_ok;
        logic nregs_zero;
        logic last_reg;
    } t_dp_sts;

    // One byte through the reflected CRC-16, bit at a time
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mbfc03_ctrl.sv -----
`default_nettype none

module mbfc03_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_frame_end,
    output logic                o_in_stall,
    input  mbfc03_pkg::t_dp_sts i_sts,
    output mbfc03_pkg::t_dp_cmd o_cmd
);
    import mbfc03_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RECV;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_RECV: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.byte_en = 1'b1;
                    if (i_frame_end) begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                o_cmd.idx_clr = 1'b1;
                if (i_sts.frame_ok && !i_sts.nregs_zero) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_STAT;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_reg = 1'b1;
                    n_state        = i_sts.last_reg ? S_STAT : S_READ;
                end
            end
            S_STAT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_stat = 1'b1;
                    n_state         = S_RECV;
                end
            end
            default: n_state = S_RECV;
        endcase
    end

    a_end_goes_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RECV && i_in_valid && i_frame_end) |=> (r_state == S_EVAL))
        else $error("final byte did not start evaluation");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_reg || o_cmd.load_stat) |-> i_sts.out_free)
        else $error("output register overwritten while held");

    a_no_bytes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RECV) |-> !o_cmd.byte_en)
        else $error("byte taken while emitting");

endmodule

`default_nettype wire

// ----- hdl/mbfc03_dpath.sv -----
`default_nettype none

module mbfc03_dpath #(
    parameter int REG_DEPTH = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_valid,
    input  wire  [5:0]          i_cfg_max_register_count,
    input  wire  [7:0]          i_rx_byte,
    input  wire                 i_out_stall,
    input  mbfc03_pkg::t_dp_cmd i_cmd,
    output mbfc03_pkg::t_dp_sts o_sts,
    output logic                o_out_valid,
    output logic                o_item_kind,
    output logic [4:0]          o_reg_index,
    output logic [15:0]         o_reg_value,
    output logic [2:0]          o_status_code,
    output logic [5:0]          o_reg_total,
    output logic                o_is_last
);
    import mbfc03_pkg::*;

    localparam int AW = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;
    localparam int CW = $clog2(REG_DEPTH + 1);
    localparam logic [8:0] DEPTH_9 = 9'(REG_DEPTH);
    localparam logic [6:0] DEPTH_7 = 7'(REG_DEPTH);

    logic [5:0]    r_max_regs;
    logic [8:0]    r_byte_pos;
    logic [15:0]   r_crc;
    logic [7:0]    r_count;
    logic [15:0]   r_rx_crc;
    logic [7:0]    r_high;
    logic [15:0]   r_rd_data;
    logic [CW-1:0] r_idx;
    logic [15:0]   r_store [REG_DEPTH];

    logic          r_out_valid;
    logic          r_item_kind;
    logic [4:0]    r_reg_index;
    logic [15:0]   r_reg_value;
    logic [2:0]    r_status_code;
    logic [5:0]    r_reg_total;
    logic          r_is_last;

    // byte handling
    logic [7:0]    count_eff;
    logic [9:0]    data_end;
    logic [8:0]    offset;
    logic [7:0]    word_idx;
    logic          in_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;

    // frame check
    logic [6:0]    nregs;
    logic [6:0]    limit;
    logic [9:0]    need_len;
    t_status       status;
    logic [CW+4:0] idx_wide;

    always_comb begin
        count_eff = (r_byte_pos == POS_COUNT) ? i_rx_byte : r_count;
        data_end  = {1'b0, HEADER_LEN} + {2'b00, count_eff};
        offset    = r_byte_pos - HEADER_LEN;
        word_idx  = offset[8:1];
        in_data   = {1'b0, r_byte_pos} < data_end;
        mem_we    = i_cmd.byte_en && in_data && (r_byte_pos >= HEADER_LEN) && offset[0]
                    && ({1'b0, word_idx} < DEPTH_9);
        mem_waddr = word_idx[AW-1:0];
    end

    always_comb begin
        nregs    = r_count[7:1];
        limit    = ({1'b0, r_max_regs} > DEPTH_7) ? DEPTH_7 : {1'b0, r_max_regs};
        need_len = {2'b00, r_count} + {1'b0, MIN_LEN};
        if (r_byte_pos < MIN_LEN) begin
            status = ST_SHORT;
        end else if (r_count[0]) begin
            status = ST_ODD_COUNT;
        end else if (nregs > limit) begin
            status = ST_TOO_MANY;
        end else if ({1'b0, r_byte_pos} < need_len) begin
            status = ST_TRUNCATED;
        end else if (r_crc != r_rx_crc) begin
            status = ST_CRC_BAD;
        end else begin
            status = ST_OK;
        end
        idx_wide = {5'b00000, r_idx};
    end

    assign o_sts.out_free   = !r_out_valid || !i_out_stall;
    assign o_sts.frame_ok   = (status == ST_OK);
    assign o_sts.nregs_zero = (nregs == 7'd0);
    assign o_sts.last_reg   = (8'(r_idx) + 8'd1) == {1'b0, nregs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_regs <= MAX_REGS_RST;
        end else if (i_cfg_valid) begin
            r_max_regs <= i_cfg_max_register_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_stat) begin
            r_byte_pos <= '0;
            r_crc      <= CRC_INIT;
            r_count    <= '0;
            r_rx_crc   <= '0;
            r_high     <= '0;
        end else if (i_cmd.byte_en) begin
            r_count <= count_eff;
            if (in_data) begin
                r_crc <= crc_byte(r_crc, i_rx_byte);
                if (r_byte_pos >= HEADER_LEN && !offset[0]) begin
                    r_high <= i_rx_byte;
                end
            end else if ({1'b0, r_byte_pos} == data_end) begin
                r_rx_crc[7:0] <= i_rx_byte;
            end else if ({1'b0, r_byte_pos} == data_end + 10'd1) begin
                r_rx_crc[15:8] <= i_rx_byte;
            end
            if (r_byte_pos != POS_MAX) begin
                r_byte_pos <= r_byte_pos + 9'd1;
            end
        end
    end

    // register word store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= {r_high, i_rx_byte};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_store[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.load_reg) begin
            r_idx <= r_idx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_reg || i_cmd.load_stat) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_reg) begin
            r_item_kind   <= ITEM_REG;
            r_reg_index   <= idx_wide[4:0];
            r_reg_value   <= r_rd_data;
            r_status_code <= ST_OK;
            r_reg_total   <= '0;
            r_is_last     <= 1'b0;
        end else if (i_cmd.load_stat) begin
            r_item_kind   <= ITEM_STATUS;
            r_reg_index   <= '0;
            r_reg_value   <= '0;
            r_status_code <= status;
            r_reg_total   <= (status == ST_OK) ? nregs[5:0] : 6'd0;
            r_is_last     <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_item_kind   = r_item_kind;
    assign o_reg_index   = r_reg_index;
    assign o_reg_value   = r_reg_value;
    assign o_status_code = r_status_code;
    assign o_reg_total   = r_reg_total;
    assign o_is_last     = r_is_last;

    a_clear_after_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_stat |=> (r_byte_pos == 9'd0 && r_crc == CRC_INIT && r_count == 8'd0))
        else $error("frame state not cleared after status");

    a_reg_item_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_reg |=> (r_out_valid && r_item_kind == ITEM_REG && !r_is_last))
        else $error("register item malformed");

    a_stat_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_stat |=> (r_out_valid && r_item_kind == ITEM_STATUS && r_is_last))
        else $error("status item malformed");

endmodule

`default_nettype wire

// ----- hdl/modbus_fc03_response_parser.sv -----
`default_nettype none

// Channel   Direction  Handshake          Payload
// ------    ---------  -----------------  ---------------------------------------------
// in        slave      i_in_valid/o_in_stall    i_rx_byte, i_frame_end
// out       master     o_out_valid/i_out_stall  o_item_kind, o_reg_index, o_reg_value,
//                                               o_status_code, o_reg_total, o_is_last
// cfg       slave      i_cfg_valid/o_cfg_ready  i_cfg_max_register_count
//
// Bytes are taken one per cycle while the frame is being received.
// The final byte moves the block to an evaluation state; an ok frame then
// emits each register by a store read followed by an output load, then the
// status item, and the input stays stalled until the status item is loaded.
// Reset is synchronous and active low; it needs no clearing pass.
// A stall on the output holds the emission sequence in place.

module modbus_fc03_response_parser #(
    parameter int REG_DEPTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // byte input
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [7:0]  i_rx_byte,
    input  wire         i_frame_end,
    // result output
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_item_kind,
    output logic [4:0]  o_reg_index,
    output logic [15:0] o_reg_value,
    output logic [2:0]  o_status_code,
    output logic [5:0]  o_reg_total,
    output logic        o_is_last,
    // configuration
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [5:0]  i_cfg_max_register_count
);
    import mbfc03_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // config transfers are always taken; the sender writes only while no
    // frame is in flight
    assign o_cfg_ready = 1'b1;

    // sequence receive, evaluate and emit
    mbfc03_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_frame_end (i_frame_end),
        .o_in_stall  (o_in_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // CRC, frame counters, word store and output register
    mbfc03_dpath #(
        .REG_DEPTH (REG_DEPTH)
    ) u_dpath (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cfg_valid              (i_cfg_valid),
        .i_cfg_max_register_count (i_cfg_max_register_count),
        .i_rx_byte                (i_rx_byte),
        .i_out_stall              (i_out_stall),
        .i_cmd                    (cmd),
        .o_sts                    (sts),
        .o_out_valid              (o_out_valid),
        .o_item_kind              (o_item_kind),
        .o_reg_index              (o_reg_index),
        .o_reg_value              (o_reg_value),
        .o_status_code            (o_status_code),
        .o_reg_total              (o_reg_total),
        .o_is_last                (o_is_last)
    );

endmodule

`default_nettype wire

// ----- tb/fc03_response_checker.sv -----
`timescale 1ns / 1ps

module fc03_response_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    input  wire        i_in_stall,
    input  wire [7:0]  i_rx_byte,
    input  wire        i_frame_end,
    input  wire        i_out_valid,
    input  wire        i_out_stall,
    input  wire        i_item_kind,
    input  wire [4:0]  i_reg_index,
    input  wire [15:0] i_reg_value,
    input  wire [2:0]  i_status_code,
    input  wire [5:0]  i_reg_total,
    input  wire        i_is_last,
    input  wire        i_cfg_valid,
    input  wire        i_cfg_ready,
    input  wire [5:0]  i_cfg_max_register_count,
    output int         o_mismatches,
    output int         o_pending
);
    import mbfc03_pkg::*;

    localparam int          WORD_SLOTS = 32;
    localparam int          POS_LIMIT  = 511;
    localparam int          COUNT_POS  = 2;
    localparam int          HDR_BYTES  = 3;
    localparam int          MIN_FRAME  = 5;
    localparam logic [15:0] CRC_SEED   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_R = 16'hA001;

    typedef struct packed {
        logic        kind;
        logic [4:0]  index;
        logic [15:0] value;
        t_status     status;
        logic [5:0]  total;
        logic        last;
    } t_result;

    t_result     awaited_results[$];
    logic [5:0]  reg_limit;
    int          frame_pos;
    logic [15:0] frame_crc;
    logic [7:0]  frame_count;
    logic [15:0] trailer_crc;
    logic [7:0]  high_hold;
    logic [15:0] reg_words [WORD_SLOTS];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY_R) : (c >> 1);
        return c;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    task automatic start_new_frame();
        frame_pos   = 0;
        frame_crc   = CRC_SEED;
        frame_count = '0;
        trailer_crc = '0;
        high_hold   = '0;
    endtask

    // Advance the frame parser by one byte; on the final byte queue its results
    task automatic parse_rx_byte(input logic [7:0] b, input logic final_byte);
        int      p;
        int      off;
        int      len;
        int      nregs;
        int      lim;
        t_status st;
        t_result r;
        p = frame_pos;
        if (p == COUNT_POS)
            frame_count = b;
        if (p < HDR_BYTES + frame_count) begin
            frame_crc = crc16_step(frame_crc, b);
            if (p >= HDR_BYTES) begin
                off = p - HDR_BYTES;
                if (off % 2 == 0)
                    high_hold = b;
                else if (off / 2 < WORD_SLOTS)
                    reg_words[off / 2] = {high_hold, b};
            end
        end else if (p == HDR_BYTES + frame_count) begin
            trailer_crc[7:0] = b;
        end else if (p == HDR_BYTES + 1 + frame_count) begin
            trailer_crc[15:8] = b;
        end
        if (frame_pos < POS_LIMIT)
            frame_pos++;
        if (!final_byte)
            return;

        len   = p + 1;
        nregs = frame_count / 2;
        lim   = (reg_limit > WORD_SLOTS) ? WORD_SLOTS : reg_limit;
        if (len < MIN_FRAME)
            st = ST_SHORT;
        else if (frame_count[0])
            st = ST_ODD_COUNT;
        else if (nregs > lim)
            st = ST_TOO_MANY;
        else if (len < frame_count + MIN_FRAME)
            st = ST_TRUNCATED;
        else if (frame_crc != trailer_crc)
            st = ST_CRC_BAD;
        else
            st = ST_OK;

        if (st == ST_OK) begin
            for (int i = 0; i < nregs && i < WORD_SLOTS; i++) begin
                r.kind   = ITEM_REG;
                r.index  = 5'(i);
                r.value  = reg_words[i];
                r.status = ST_OK;
                r.total  = '0;
                r.last   = 1'b0;
                awaited_results.push_back(r);
            end
        end
        r.kind   = ITEM_STATUS;
        r.index  = '0;
        r.value  = '0;
        r.status = st;
        r.total  = (st == ST_OK) ? 6'(nregs) : 6'd0;
        r.last   = 1'b1;
        awaited_results.push_back(r);
        start_new_frame();
    endtask

    task automatic check_result();
        t_result want;
        if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("result with none awaited: kind %0d code %0d",
                                      i_item_kind, i_status_code));
            return;
        end
        want = awaited_results.pop_front();
        compare_field("item_kind", 16'(i_item_kind), 16'(want.kind));
        compare_field("reg_index", 16'(i_reg_index), 16'(want.index));
        compare_field("reg_value", i_reg_value, want.value);
        compare_field("status_code", 16'(i_status_code), 16'(want.status));
        compare_field("reg_total", 16'(i_reg_total), 16'(want.total));
        compare_field("is_last", 16'(i_is_last), 16'(want.last));
    endtask

    // Sample pre-edge values; retire results before taking the new byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_limit = MAX_REGS_RST;
            start_new_frame();
            foreach (reg_words[i]) reg_words[i] = '0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_result();
            if (i_cfg_valid && i_cfg_ready)
                reg_limit = i_cfg_max_register_count;
            if (i_in_valid && !i_in_stall)
                parse_rx_byte(i_rx_byte, i_frame_end);
        end
        o_pending = awaited_results.size();
    end

endmodule

// ----- tb/modbus_fc03_response_parser_tb.sv -----
`timescale 1ns / 1ps

module modbus_fc03_response_parser_tb;

    import mbfc03_pkg::*;

    // Frame building
    localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
    localparam logic [15:0] CRC_SEED        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_R      = 16'hA001;
    localparam int          WORD_SLOTS      = 32;
    // Run control
    localparam int          PHASES          = 6;
    localparam int          PHASE_BYTES     = 56;
    localparam int          QUIET_CYCLES    = 8;
    localparam int          CYCLE_LIMIT     = 300000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_rx_byte = '0;
    logic        i_frame_end = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [5:0]  i_cfg_max_register_count = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_item_kind;
    logic [4:0]  o_reg_index;
    logic [15:0] o_reg_value;
    logic [2:0]  o_status_code;
    logic [5:0]  o_reg_total;
    logic        o_is_last;
    logic        o_cfg_ready;

    int          mismatches;
    int          pending;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          phase_bytes;
    logic [7:0]  frame_q[$];
    logic [5:0]  phase_limit [PHASES];

    always #2 i_clk = ~i_clk;

    modbus_fc03_response_parser dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_in_valid               (i_in_valid),
        .o_in_stall               (o_in_stall),
        .i_rx_byte                (i_rx_byte),
        .i_frame_end              (i_frame_end),
        .o_out_valid              (o_out_valid),
        .i_out_stall              (i_out_stall),
        .o_item_kind              (o_item_kind),
        .o_reg_index              (o_reg_index),
        .o_reg_value              (o_reg_value),
        .o_status_code            (o_status_code),
        .o_reg_total              (o_reg_total),
        .o_is_last                (o_is_last),
        .i_cfg_valid              (i_cfg_valid),
        .o_cfg_ready              (o_cfg_ready),
        .i_cfg_max_register_count (i_cfg_max_register_count)
    );

    fc03_response_checker checker_i (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_in_valid               (i_in_valid),
        .i_in_stall               (o_in_stall),
        .i_rx_byte                (i_rx_byte),
        .i_frame_end              (i_frame_end),
        .i_out_valid              (o_out_valid),
        .i_out_stall              (i_out_stall),
        .i_item_kind              (o_item_kind),
        .i_reg_index              (o_reg_index),
        .i_reg_value              (o_reg_value),
        .i_status_code            (o_status_code),
        .i_reg_total              (o_reg_total),
        .i_is_last                (o_is_last),
        .i_cfg_valid              (i_cfg_valid),
        .i_cfg_ready              (o_cfg_ready),
        .i_cfg_max_register_count (i_cfg_max_register_count),
        .o_mismatches             (mismatches),
        .o_pending                (pending)
    );

    // Receiver back-pressure: a fresh coin every cycle, so stalls land on
    // every step of the emission sequence
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Offer one byte and hold it until the transfer completes. Valid stays
    // high between back-to-back bytes; it only drops for an idle gap.
    task automatic send_byte(input logic [7:0] b, input logic final_byte);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_rx_byte   <= b;
        i_frame_end <= final_byte;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Assemble a response in frame_q: id, function code, count byte, data,
    // CRC low then high, then any trailing bytes. A fill of -1 means random
    // id and data; otherwise both take the fill value.
    task automatic build_frame(input int count, input int data_len, input bit crc_good,
                               input int trailing, input int fill);
        logic [15:0] crc;
        frame_q.delete();
        frame_q.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
        // the block ignores the function code, so vary it now and then
        frame_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                      : FC_READ_HOLDING);
        frame_q.push_back(8'(count));
        repeat (data_len)
            frame_q.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
        crc = CRC_SEED;
        foreach (frame_q[i]) begin
            crc ^= {8'h00, frame_q[i]};
            repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY_R) : (crc >> 1);
        end
        if (!crc_good)
            crc ^= 16'h0001 << $urandom_range(0, 15);
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
        repeat (trailing) frame_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // Send the first len bytes of frame_q (all of it if len is 0), marking
    // the last one sent as the frame end
    task automatic send_frame(input int len);
        int n;
        n = (len > 0 && len < frame_q.size()) ? len : frame_q.size();
        for (int i = 0; i < n; i++)
            send_byte(frame_q[i], i == n - 1);
        phase_bytes += n;
    endtask

    // Drop valid and hold off until every awaited result has been seen,
    // then give the block time to settle
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg_limit(input logic [5:0] v);
        i_cfg_max_register_count <= v;
        i_cfg_valid              <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // One random frame; mostly well formed so that the register path is
    // exercised, the rest broken in each way the block reports
    task automatic random_frame(input int eff);
        int r;
        int n;
        int c;
        r = $urandom_range(0, 99);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, eff)
                                         : $urandom_range(0, (eff < 4) ? eff : 4);
        if (r < 58) begin
            build_frame(2 * n, 2 * n, 1'b1,
                        ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0, -1);
            send_frame(0);
        end else if (r < 66) begin
            build_frame(2 * n, 2 * n, 1'b0, 0, -1);
            send_frame(0);
        end else if (r < 72) begin
            build_frame(2 * n + 1, 2 * n + 1, 1'b1, 0, -1);
            send_frame(0);
        end else if (r < 78) begin
            // over the limit: only part of the data is sent; the limit check wins over truncation
            n = $urandom_range(eff + 1, 127);
            build_frame(2 * n, $urandom_range(2, 8), 1'b1, 0, -1);
            send_frame(0);
        end else if (r < 86) begin
            build_frame(2 * n, 2 * n, 1'b1, 0, -1);
            send_frame($urandom_range(1, 2 * n + 4));
        end else if (r < 94) begin
            build_frame(0, 0, 1'b1, 0, -1);
            send_frame($urandom_range(1, 4));
        end else begin
            c = $urandom_range(0, 255);
            build_frame(c, $urandom_range(0, (c < 40) ? c : 40), 1'($urandom_range(0, 1)),
                        $urandom_range(0, 3), -1);
            send_frame(0);
        end
    endtask

    initial begin
        int eff;

        // Limit per phase: top of the field, zero, one, inside, at and
        // above the buffer depth
        phase_limit[0] = 6'd63;
        phase_limit[1] = 6'd0;
        phase_limit[2] = 6'd1;
        phase_limit[3] = 6'($urandom_range(2, 31));
        phase_limit[4] = 6'd32;
        phase_limit[5] = 6'($urandom_range(33, 62));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the reset limit
        send_idle_pct  = 9;
        recv_stall_pct = 78;
        phase_bytes    = 0;
        build_frame(0, 0, 1'b1, 0, -1);
        send_frame(1);                      // lone byte: too short
        build_frame(0, 0, 1'b1, 0, -1);
        send_frame(4);                      // one byte short of the minimum
        build_frame(0, 0, 1'b1, 0, 0);
        send_frame(0);                      // smallest good frame, no registers
        build_frame(2, 2, 1'b1, 0, 255);
        send_frame(0);                      // one register at full scale
        build_frame(1, 1, 1'b1, 0, -1);
        send_frame(0);                      // odd count byte
        build_frame(66, 2, 1'b1, 0, -1);
        send_frame(0);                      // one register beyond the depth
        build_frame(2, 2, 1'b1, 0, -1);
        send_frame(6);                      // CRC high byte missing
        build_frame(0, 0, 1'b0, 0, -1);
        send_frame(0);                      // corrupted CRC
        build_frame(0, 0, 1'b1, 2, -1);
        send_frame(0);                      // trailing bytes after the CRC
        // hold the sender until the whole backlog has drained
        wait_quiet();

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_quiet();
            if (ph < 2) begin
                send_idle_pct  = 9;
                recv_stall_pct = 78;
            end else if (ph < 4) begin
                send_idle_pct  = 78;
                recv_stall_pct = 9;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_reg_limit(phase_limit[ph]);
            eff = (phase_limit[ph] > WORD_SLOTS) ? WORD_SLOTS : phase_limit[ph];
            phase_bytes = 0;

            // Exactly at the limit, then one register past it
            build_frame(2 * eff, 2 * eff, 1'b1, 0, -1);
            send_frame(0);
            build_frame(2 * (eff + 1), 4, 1'b1, 0, -1);
            send_frame(0);
            while (phase_bytes < PHASE_BYTES)
                random_frame(eff);
        end

        wait_quiet();
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- modbus_fc03_response_parser.f -----
hdl/mbfc03_pkg.sv
hdl/mbfc03_ctrl.sv
hdl/mbfc03_dpath.sv
hdl/modbus_fc03_response_parser.sv
tb/fc03_response_checker.sv
tb/modbus_fc03_response_parser_tb.sv
